[rtl/joystick_debounce_autorepeat_assert.svh]
// Assertion macros shared by the joystick debounce and auto-repeat RTL.
// Each module that asserts includes this header; it needs a clk and rst in scope.
`ifndef JOYSTICK_DEBOUNCE_AUTOREPEAT_ASSERT_SVH
`define JOYSTICK_DEBOUNCE_AUTOREPEAT_ASSERT_SVH

// Same-cycle implication, disabled while reset is applied.
`define JDA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define JDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/jda_pkg.sv]
// Package for the joystick debounce and auto-repeat block: payload types,
// register indexes, controller states and the controller/datapath interface.
package jda_pkg;

  localparam int RATE_STEPS = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;
  localparam int REM_CYCLES = 16;

  typedef struct packed {
    logic [4:0] buttons;
    logic       output_active;
    logic       guard_screen;
    logic       home_screen;
  } in_item_t;

  typedef struct packed {
    logic       menu_valid;
    logic [4:0] menu_buttons;
    logic       enable_request;
    logic       disable_request;
    logic       redraw_valid;
    logic       redraw_full;
  } out_item_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_THRESHOLD = 3'd0,
    CFG_REPEAT_INTERVAL    = 3'd1,
    CFG_MENU_PHASE         = 3'd2,
    CFG_REDRAW_PERIOD      = 3'd3,
    CFG_RATE_TABLE         = 3'd4
  } cfg_idx_t;

  localparam logic [4:0] BTN_UP     = 5'h01;
  localparam logic [4:0] BTN_DOWN   = 5'h02;
  localparam logic [4:0] BTN_SELECT = 5'h10;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_REM_A,
    S_APPLY,
    S_MENU,
    S_REM_B,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic start_a;
    logic start_b;
    logic capture_bnd;
    logic apply;
    logic menu_chk;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic act;
    logic bnd_possible;
    logic div_nz;
    logic rem_done;
    logic out_free;
  } stat_t;

endpackage

[rtl/joystick_debounce_autorepeat.sv]
// Top level of the joystick debounce and accelerating auto-repeat block.
// Depends on jda_pkg, jda_ctrl, jda_dp and jda_rem.
//
// Each accepted item is one sampling tick and yields exactly one result item.
// Items are handled one at a time. A tick whose sample is not qualified, or
// is released, goes from check straight to finish. A qualified press runs up
// to two remainders on the shared unit, which retires two dividend bits per
// cycle: hold count by repeat interval when a boundary is possible, then hold
// count by the current rate divisor when that divisor is nonzero.
// A finished result sits in an output register, so the next item is taken
// while it waits; configuration writes are always ready and belong in idle
// periods.
module joystick_debounce_autorepeat
  import jda_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  jda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  jda_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/jda_rem.sv]
// Iterative remainder unit: 32-bit dividend by a nonzero 16-bit divisor,
// two restoring steps per cycle. Depends on jda_pkg.
module jda_rem
  import jda_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] remainder
);

  localparam int CntW = $clog2(REM_CYCLES);

  logic [31:0]     dvd;
  logic [15:0]     dsr;
  logic [15:0]     rem;
  logic [CntW-1:0] cnt;
  logic            busy;
  logic [15:0]     r1;
  logic [15:0]     r2;

  function automatic logic [15:0] rem_step(input logic [15:0] r, input logic b,
                                           input logic [15:0] d);
    logic [16:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[15:0];
  endfunction

  always_comb begin
    r1 = rem_step(rem, dvd[31], dsr);
    r2 = rem_step(r1, dvd[30], dsr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(REM_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[29:0], 2'b00};
      rem <= r2;
    end
  end

  assign remainder = rem;

endmodule

[rtl/jda_dp.sv]
// Datapath: configuration registers, debounce and hold state, the shared
// remainder unit and the output register. Depends on jda_pkg and jda_rem.
module jda_dp
  import jda_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_item_t              in_data,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data
);

  // Configuration registers.
  logic [15:0] debounce_threshold;
  logic [15:0] repeat_interval;
  logic [7:0]  menu_phase;
  logic [15:0] redraw_period;
  logic [39:0] rate_table;

  // Block state.
  logic [4:0]  previous_sample;
  logic [15:0] stable_count;
  logic [31:0] hold_count;
  logic [2:0]  rate_level;
  logic        released_flag;
  logic [15:0] redraw_count;

  // Current item and its partial results.
  in_item_t    item;
  logic        bnd;
  logic        menu_v;
  logic        en_req;
  logic        dis_req;

  logic        qual;
  logic        nz;
  logic [63:0] table_wide;
  logic [7:0]  divisor;
  logic        rem_done;
  logic [15:0] rem_out;
  logic [15:0] rem_divisor;
  logic        out_free;
  logic        redraw_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_threshold <= 16'd50;
      repeat_interval    <= 16'd500;
      menu_phase         <= 8'd0;
      redraw_period      <= 16'd100;
      rate_table         <= 40'h0A193264C8;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEBOUNCE_THRESHOLD: debounce_threshold <= cfg_data[15:0];
        CFG_REPEAT_INTERVAL:    repeat_interval    <= cfg_data[15:0];
        CFG_MENU_PHASE:         menu_phase         <= cfg_data[7:0];
        CFG_REDRAW_PERIOD:      redraw_period      <= cfg_data[15:0];
        CFG_RATE_TABLE:         rate_table         <= cfg_data;
        default: ;
      endcase
    end
  end

  // Levels past the packed bytes read as a zero divisor.
  assign table_wide = {24'd0, rate_table};
  assign divisor    = table_wide[{rate_level, 3'b000} +: 8];

  assign qual     = stable_count >= debounce_threshold;
  assign nz       = item.buttons != 5'd0;
  assign out_free = !out_valid || !out_stall;
  assign redraw_hit = !(redraw_count < redraw_period);

  assign stat.act          = qual && nz;
  assign stat.bnd_possible = (repeat_interval != 16'd0) && (hold_count != 32'd0);
  assign stat.div_nz       = divisor != 8'd0;
  assign stat.rem_done     = rem_done;
  assign stat.out_free     = out_free;

  assign rem_divisor = cmd.start_a ? repeat_interval : {8'd0, divisor};

  jda_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.start_a || cmd.start_b),
    .dividend  (hold_count),
    .divisor   (rem_divisor),
    .done      (rem_done),
    .remainder (rem_out)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
      stable_count    <= '0;
      hold_count      <= '0;
      rate_level      <= '0;
      released_flag   <= 1'b0;
      redraw_count    <= '0;
      bnd             <= 1'b0;
      menu_v          <= 1'b0;
      en_req          <= 1'b0;
      dis_req         <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        bnd     <= 1'b0;
        menu_v  <= 1'b0;
        en_req  <= 1'b0;
        dis_req <= 1'b0;
      end
      if (cmd.capture_bnd) begin
        bnd <= rem_out == 16'd0;
      end
      if (cmd.apply) begin
        if (bnd) begin
          if (item.buttons == BTN_UP || item.buttons == BTN_DOWN) begin
            if ((4'(rate_level) + 4'd1) < 4'(RATE_STEPS)) begin
              rate_level <= rate_level + 3'd1;
            end
          end else if (item.buttons == BTN_SELECT) begin
            if (!item.output_active && !item.guard_screen) begin
              en_req        <= 1'b1;
              released_flag <= 1'b0;
            end
          end
        end else begin
          dis_req <= item.output_active && released_flag;
        end
      end
      if (cmd.menu_chk) begin
        menu_v <= rem_out == {8'd0, menu_phase};
      end
      if (cmd.commit) begin
        if (qual) begin
          if (nz) begin
            hold_count <= hold_count + 32'd1;
          end else begin
            released_flag <= 1'b1;
            hold_count    <= '0;
            rate_level    <= '0;
          end
        end
        if (item.buttons == previous_sample) begin
          if (stable_count != 16'hFFFF) begin
            stable_count <= stable_count + 16'd1;
          end
        end else begin
          stable_count <= '0;
        end
        previous_sample <= item.buttons;
        if (redraw_hit) begin
          redraw_count <= '0;
        end else begin
          redraw_count <= redraw_count + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data.menu_valid      <= menu_v;
      out_data.menu_buttons    <= menu_v ? item.buttons : 5'd0;
      out_data.enable_request  <= en_req;
      out_data.disable_request <= dis_req;
      out_data.redraw_valid    <= redraw_hit;
      out_data.redraw_full     <= redraw_hit && item.home_screen;
    end
  end

`include "joystick_debounce_autorepeat_assert.svh"

  `JDA_ASSERT_NOW(a_level_range, 1'b1, 4'(rate_level) < 4'(RATE_STEPS), "rate level out of range")
  `JDA_ASSERT_NOW(a_commit_free, cmd.commit, out_free, "result overwritten before taken")
  `JDA_ASSERT_NOW(a_div_nonzero, cmd.start_a || cmd.start_b, rem_divisor != 16'd0,
                  "remainder started with zero divisor")
  `JDA_ASSERT_NOW(a_menu_buttons, out_valid && out_data.menu_valid,
                  out_data.menu_buttons != 5'd0, "menu action without buttons")

endmodule

[rtl/jda_ctrl.sv]
// Controller state machine: sequences one item through the boundary check,
// the menu check and the commit. Depends on jda_pkg.
module jda_ctrl
  import jda_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = state != S_IDLE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat.act) begin
          state_next = S_FINISH;
        end else if (stat.bnd_possible) begin
          cmd.start_a = 1'b1;
          state_next  = S_REM_A;
        end else begin
          state_next = S_APPLY;
        end
      end
      S_REM_A: begin
        if (stat.rem_done) begin
          cmd.capture_bnd = 1'b1;
          state_next      = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_MENU;
      end
      S_MENU: begin
        // The divisor here already reflects a rate step taken this item.
        if (stat.div_nz) begin
          cmd.start_b = 1'b1;
          state_next  = S_REM_B;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_REM_B: begin
        if (stat.rem_done) begin
          cmd.menu_chk = 1'b1;
          state_next   = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

`include "joystick_debounce_autorepeat_assert.svh"

  `JDA_ASSERT_NOW(a_done_waited, stat.rem_done, state == S_REM_A || state == S_REM_B,
                  "remainder finished outside a wait state")
  `JDA_ASSERT_NEXT(a_load_check, cmd.load, state == S_CHECK, "load not followed by check")
  `JDA_ASSERT_NEXT(a_commit_idle, cmd.commit, state == S_IDLE && !in_stall,
                   "commit not followed by idle")

endmodule

[verif/joystick_debounce_autorepeat_test.sv]
// Testbench for joystick_debounce_autorepeat: drives sampling ticks and register writes,
// predicts every result item in the bench and compares it field by field.
// Depends on jda_pkg and the joystick_debounce_autorepeat RTL.
`timescale 1ns / 100ps

module joystick_debounce_autorepeat_test;
  import jda_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 48;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  joystick_debounce_autorepeat i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register copies kept by the predictor.
  logic [15:0] threshold_q;
  logic [15:0] interval_q;
  logic [7:0]  phase_q;
  logic [15:0] period_q;
  logic [39:0] divisors_q;

  // Tick state kept by the predictor.
  logic [4:0]  last_buttons;
  logic [15:0] stable_q;
  logic [31:0] hold_q;
  logic [2:0]  level_q;
  logic        released_q;
  logic [15:0] redraw_q;

  out_item_t expected_results[$];
  int        sent_count;
  int        results_seen;
  int        mismatches;
  int        quiet_cycles;
  bit        steady;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Computes the result of one sampling tick and advances the predicted state.
  function automatic out_item_t advance_tick(in_item_t it);
    out_item_t  r;
    logic       bnd;
    logic [7:0] div;
    r = '0;
    if (stable_q >= threshold_q) begin
      if (it.buttons != 5'd0) begin
        bnd = (interval_q != 16'd0) && (hold_q != 32'd0) && ((hold_q % interval_q) == 32'd0);
        if (bnd) begin
          if (it.buttons == BTN_UP || it.buttons == BTN_DOWN) begin
            if (level_q < RATE_STEPS - 1) level_q = level_q + 3'd1;
          end else if (it.buttons == BTN_SELECT && !it.output_active && !it.guard_screen) begin
            r.enable_request = 1'b1;
            released_q = 1'b0;
          end
        end else begin
          r.disable_request = it.output_active & released_q;
        end
        div = divisors_q[8*level_q +: 8];
        if (div != 8'd0 && (hold_q % div) == phase_q) begin
          r.menu_valid   = 1'b1;
          r.menu_buttons = it.buttons;
        end
        hold_q = hold_q + 32'd1;
      end else begin
        released_q = 1'b1;
        hold_q     = 32'd0;
        level_q    = 3'd0;
      end
    end
    if (it.buttons == last_buttons) begin
      if (stable_q != 16'hFFFF) stable_q = stable_q + 16'd1;
    end else begin
      stable_q = 16'd0;
    end
    last_buttons = it.buttons;
    if (redraw_q < period_q) begin
      redraw_q = redraw_q + 16'd1;
    end else begin
      r.redraw_valid = 1'b1;
      r.redraw_full  = it.home_screen;
      redraw_q       = 16'd0;
    end
    return r;
  endfunction

  function automatic string show_result(out_item_t r);
    return $sformatf("menu %b/%h enable %b disable %b redraw %b/%b", r.menu_valid,
                     r.menu_buttons, r.enable_request, r.disable_request, r.redraw_valid,
                     r.redraw_full);
  endfunction

  task automatic send_item(input in_item_t it);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 9) gap = $urandom_range(1, 3);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(advance_tick(it));
    sent_count++;
  endtask

  task automatic repeat_item(input logic [4:0] btn, input logic act, input logic grd,
                             input logic home, input int n);
    in_item_t it;
    it.buttons       = btn;
    it.output_active = act;
    it.guard_screen  = grd;
    it.home_screen   = home;
    repeat (n) send_item(it);
  endtask

  // Lets the block run dry so that registers may be written.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [39:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DEBOUNCE_THRESHOLD: threshold_q = val[15:0];
      CFG_REPEAT_INTERVAL:    interval_q  = val[15:0];
      CFG_MENU_PHASE:         phase_q     = val[7:0];
      CFG_REDRAW_PERIOD:      period_q    = val[15:0];
      CFG_RATE_TABLE:         divisors_q  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] thr, input logic [15:0] intv,
                            input logic [7:0] phase, input logic [15:0] period,
                            input logic [39:0] divs);
    settle();
    write_reg(CFG_DEBOUNCE_THRESHOLD, 40'(thr));
    write_reg(CFG_REPEAT_INTERVAL, 40'(intv));
    write_reg(CFG_MENU_PHASE, 40'(phase));
    write_reg(CFG_REDRAW_PERIOD, 40'(period));
    write_reg(CFG_RATE_TABLE, divs);
  endtask

  // Mostly held presses followed by releases, with bounces and bursts of noise mixed in.
  task automatic run_sequences(input int target, input int max_hold, input int max_rest,
                               input int noise_pct);
    int         start;
    int         len;
    logic [4:0] btn;
    logic       act;
    logic       grd;
    in_item_t   it;
    start = sent_count;
    while (sent_count - start < target) begin
      if ($urandom_range(99) < noise_pct) begin
        repeat ($urandom_range(1, 4)) send_item(in_item_t'(8'($urandom)));
      end else begin
        case ($urandom_range(3))
          0: btn = BTN_UP;
          1: btn = BTN_DOWN;
          2: btn = BTN_SELECT;
          default: btn = 5'($urandom_range(1, 31));
        endcase
        act = 1'($urandom_range(1));
        grd = ($urandom_range(3) == 0);
        len = $urandom_range(1, max_hold);
        repeat (len) begin
          it.buttons       = ($urandom_range(99) < 3) ? 5'($urandom) : btn;
          it.output_active = ($urandom_range(99) < 2) ? !act : act;
          it.guard_screen  = grd;
          it.home_screen   = 1'($urandom_range(1));
          send_item(it);
        end
        len = $urandom_range(1, max_rest);
        repeat (len) begin
          it = in_item_t'(8'($urandom));
          it.buttons = 5'd0;
          send_item(it);
        end
      end
    end
  endtask

  task automatic test_directed_cases();
    repeat_item(5'h00, 1'b1, 1'b1, 1'b1, 1);
    set_config(16'd0, 16'd2, 8'd0, 16'd0, 40'h05_0403_0201);
    repeat_item(5'h00, 1'b1, 1'b1, 1'b1, 1);
    repeat_item(5'h1F, 1'b0, 1'b0, 1'b0, 1);
    repeat_item(5'h1F, 1'b1, 1'b1, 1'b1, 1);
    // Up held past several boundaries steps the rate ladder.
    repeat_item(BTN_UP, 1'b0, 1'b0, 1'b1, 4);
    repeat_item(5'h00, 1'b0, 1'b0, 1'b0, 2);
    repeat_item(BTN_SELECT, 1'b0, 1'b0, 1'b1, 4);
    repeat_item(BTN_SELECT, 1'b0, 1'b1, 1'b0, 2);
    repeat_item(5'h00, 1'b1, 1'b0, 1'b0, 1);
    // A press after a release with the output active asks for disabling.
    repeat_item(BTN_SELECT, 1'b1, 1'b0, 1'b1, 3);
    repeat_item(5'h04, 1'b1, 1'b0, 1'b0, 3);
    repeat_item(5'h08, 1'b0, 1'b0, 1'b1, 1);
    repeat_item(BTN_DOWN, 1'b0, 1'b0, 1'b0, 4);
  endtask

  task automatic test_open_cases();
    // No boundary with a zero interval, and no menu action with a zero divisor.
    settle();
    write_reg(CFG_REPEAT_INTERVAL, 40'd0);
    write_reg(CFG_RATE_TABLE, 40'hFF_FFFF_FF00);
    repeat_item(5'h00, 1'b0, 1'b0, 1'b0, 2);
    repeat_item(BTN_UP, 1'b0, 1'b0, 1'b1, 6);
    repeat_item(BTN_SELECT, 1'b0, 1'b0, 1'b0, 4);
    settle();
    write_reg(CFG_RATE_TABLE, 40'd0);
    write_reg(CFG_REPEAT_INTERVAL, 40'd1);
    repeat_item(BTN_DOWN, 1'b0, 1'b0, 1'b1, 6);
  endtask

  task automatic test_default_settings();
    set_config(16'd50, 16'd500, 8'd0, 16'd100, 40'h0A_1932_64C8);
    run_sequences(200, 600, 60, 5);
  endtask

  task automatic test_fast_repeat();
    set_config(16'd2, 16'd3, 8'd1, 16'd5, 40'h05_0403_0201);
    run_sequences(200, 30, 6, 15);
  endtask

  task automatic test_back_to_back();
    set_config(16'd0, 16'd1, 8'd0, 16'd0, 40'h01_0101_0101);
    steady = 1'b1;
    run_sequences(200, 20, 3, 10);
    steady = 1'b0;
  endtask

  task automatic test_random_settings();
    logic [15:0] thr;
    logic [39:0] divs;
    repeat (4) begin
      thr = 16'($urandom_range(0, 4));
      for (int b = 0; b < 5; b++) divs[8*b +: 8] = 8'($urandom_range(0, 6));
      set_config(thr, 16'($urandom_range(1, 8)), 8'($urandom_range(0, 3)),
                 16'($urandom_range(0, 12)), divs);
      run_sequences(80, 40, int'(thr) + 4, 15);
    end
  endtask

  task automatic test_extreme_settings();
    set_config(16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 40'hFF_FFFF_FFFF);
    run_sequences(60, 20, 5, 20);
    set_config(16'd0, 16'hFFFF, 8'hFE, 16'd0, 40'hFF_FFFF_FFFF);
    run_sequences(200, 300, 4, 5);
  endtask

  always @(negedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= !steady && ($urandom_range(99) < 9);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: none expected, got %s", results_seen, show_result(out_data));
      end else begin
        want = expected_results.pop_front();
        if (out_data.menu_valid !== want.menu_valid ||
            out_data.menu_buttons !== want.menu_buttons ||
            out_data.enable_request !== want.enable_request ||
            out_data.disable_request !== want.disable_request ||
            out_data.redraw_valid !== want.redraw_valid ||
            out_data.redraw_full !== want.redraw_full) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected %s, got %s", results_seen, show_result(want),
                     show_result(out_data));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
    begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk          = 1'b0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_DEBOUNCE_THRESHOLD;
    cfg_data     = '0;
    steady       = 1'b0;
    sent_count   = 0;
    results_seen = 0;
    mismatches   = 0;
    quiet_cycles = 0;
    threshold_q  = 16'd50;
    interval_q   = 16'd500;
    phase_q      = 8'd0;
    period_q     = 16'd100;
    divisors_q   = 40'h0A_1932_64C8;
    last_buttons = 5'd0;
    stable_q     = 16'd0;
    hold_q       = 32'd0;
    level_q      = 3'd0;
    released_q   = 1'b0;
    redraw_q     = 16'd0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_open_cases();
    test_default_settings();
    test_fast_repeat();
    test_back_to_back();
    test_random_settings();
    test_extreme_settings();

    settle();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/jda_pkg.sv
rtl/jda_rem.sv
rtl/jda_dp.sv
rtl/jda_ctrl.sv
rtl/joystick_debounce_autorepeat.sv
verif/joystick_debounce_autorepeat_test.sv
